>>> rtl/prw1_pkg.sv
// Shared types and fixed widths for the pole ring wavenumber-one filter.
// Used by the sequencer, the multiply-accumulate unit, the trig table and the top level.
`timescale 1ns / 1ps

package prw1_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TRIG_W   = 16;
  localparam int OUT_W    = 16;
  localparam int SUM_W    = 40;
  localparam int RSZ_W    = 7;
  localparam int STEP_W   = 16;
  localparam int COEF_W   = 17;
  localparam int CFG_W    = 17;
  localparam int A_W      = 21;
  localparam int B_W      = 18;
  localparam int PROD_W   = A_W + B_W;
  localparam int ACC_W    = 58;
  localparam int SPLIT    = 20;

  localparam logic [STEP_W-1:0] QUARTER_TURN = 16'h4000;

  typedef enum logic [1:0] {
    REG_RING_SIZE,
    REG_PHASE_STEP,
    REG_COEF_SCALE
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_SCALE,
    S_POINT
  } state_t;

  typedef enum logic [2:0] {
    A_SAMPLE,
    A_COS,
    A_SIN,
    A_UX,
    A_UY
  } asel_t;

  typedef enum logic [1:0] {
    D_COS,
    D_SIN,
    D_ACC
  } dest_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_UX,
    ACT_UY,
    ACT_THETA
  } act_t;

  typedef struct packed {
    logic  issue;
    asel_t asel;
    logic  hi;
    logic  b_coef;
    logic  sub;
    logic  first;
    dest_t dest;
    act_t  act;
    logic  clr;
  } mac_op_t;

endpackage

>>> rtl/prw1_trig_rom.sv
// Quarter-wave cosine table with quadrant folding and a registered read.
// Table entries are built at elaboration; depends on prw1_pkg.
`timescale 1ns / 1ps

module prw1_trig_rom #(
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic                                clk,
  input  logic [prw1_pkg::STEP_W-1:0]         phase,
  output logic signed [prw1_pkg::TRIG_W-1:0]  trig_val
);

  localparam int TB     = TRIG_TABLE_BITS;
  localparam int QL     = 1 << (TB - 2);
  localparam int ADDR_W = TB - 1;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  function automatic logic [prw1_pkg::TRIG_W-1:0] rom_entry(int unsigned j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    longint      q15;
    x    = (PI_Q30 * 64'd2 * 64'(j)) >> TB;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    acc  = longint'(term);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if ((k % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q15 = (acc + 64'sd16384) >>> 15;
    if (q15 > 32767) begin
      q15 = 32767;
    end
    return q15[prw1_pkg::TRIG_W-1:0];
  endfunction

  logic [prw1_pkg::TRIG_W-1:0] quarter [0:QL];

  for (genvar j = 0; j <= QL; j++) begin : g_tab
    assign quarter[j] = rom_entry(j);
  end

  logic [TB-1:0]               idx;
  logic [1:0]                  quad;
  logic [TB-3:0]               rem;
  logic [ADDR_W-1:0]           addr;
  logic [prw1_pkg::TRIG_W-1:0] mag;
  logic                        neg;

  always_comb begin
    idx  = phase[prw1_pkg::STEP_W-1 -: TB];
    quad = idx[TB-1 -: 2];
    rem  = idx[TB-3:0];
    addr = quad[0] ? (ADDR_W'(QL) - {1'b0, rem}) : {1'b0, rem};
    mag  = quarter[addr];
    neg  = (quad == 2'd1) || (quad == 2'd2);
  end

  always_ff @(posedge clk) begin
    trig_val <= neg ? -$signed(mag) : $signed(mag);
  end

endmodule

>>> rtl/prw1_mac.sv
// Shared 21x18 multiplier with a registered product and a shift-accumulate
// stage; holds the ring sums, the scaled coefficients and the result
// accumulator. Depends on prw1_pkg.
`timescale 1ns / 1ps

module prw1_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  prw1_pkg::mac_op_t                    op,
  input  logic signed [prw1_pkg::SAMPLE_W-1:0] sample,
  input  logic [prw1_pkg::COEF_W-1:0]          coef,
  input  logic signed [prw1_pkg::TRIG_W-1:0]   trig,
  output logic signed [prw1_pkg::OUT_W-1:0]    theta,
  output logic signed [prw1_pkg::OUT_W-1:0]    phi
);

  localparam int SUM_W  = prw1_pkg::SUM_W;
  localparam int ACC_W  = prw1_pkg::ACC_W;
  localparam int PROD_W = prw1_pkg::PROD_W;
  localparam int A_W    = prw1_pkg::A_W;
  localparam int B_W    = prw1_pkg::B_W;
  localparam int SPLIT  = prw1_pkg::SPLIT;
  localparam int Q_W    = ACC_W - 30;

  logic signed [SUM_W-1:0]  cos_sum;
  logic signed [SUM_W-1:0]  sin_sum;
  logic signed [SUM_W-1:0]  ux;
  logic signed [SUM_W-1:0]  uy;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic                     vld;
  logic                     hi_r;
  logic                     sub_r;
  logic                     first_r;
  prw1_pkg::dest_t          dest_r;

  logic [SUM_W-1:0]         src;
  logic signed [A_W-1:0]    a;
  logic signed [B_W-1:0]    b;
  logic signed [ACC_W-1:0]  ext;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  rnd16;
  logic signed [ACC_W-1:0]  rnd30;
  logic [Q_W-1:0]           q;

  function automatic logic [prw1_pkg::OUT_W-1:0] sat16(logic [Q_W-1:0] v);
    if ((&v[Q_W-1:15]) || !(|v[Q_W-1:15])) begin
      return v[15:0];
    end
    return v[Q_W-1] ? 16'h8000 : 16'h7FFF;
  endfunction

  always_comb begin
    unique case (op.asel)
      prw1_pkg::A_COS: src = cos_sum;
      prw1_pkg::A_SIN: src = sin_sum;
      prw1_pkg::A_UX:  src = ux;
      prw1_pkg::A_UY:  src = uy;
      default:         src = {{(SUM_W-prw1_pkg::SAMPLE_W){sample[prw1_pkg::SAMPLE_W-1]}},
                              sample};
    endcase
    if (op.asel == prw1_pkg::A_SAMPLE) begin
      a = {{(A_W-prw1_pkg::SAMPLE_W){sample[prw1_pkg::SAMPLE_W-1]}}, sample};
    end else if (op.hi) begin
      a = {src[SUM_W-1], src[SUM_W-1:SPLIT]};
    end else begin
      a = {1'b0, src[SPLIT-1:0]};
    end
    b = op.b_coef ? {1'b0, coef} : {{(B_W-prw1_pkg::TRIG_W){trig[prw1_pkg::TRIG_W-1]}}, trig};
  end

  always_comb begin
    ext   = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    term  = hi_r ? (ext <<< SPLIT) : ext;
    term  = sub_r ? -term : term;
    rnd16 = acc + (ACC_W'(1) <<< 15);
    rnd30 = acc + (ACC_W'(1) <<< 29);
    q     = rnd30[ACC_W-1:30];
    phi   = sat16(q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= 1'b0;
      cos_sum <= '0;
      sin_sum <= '0;
    end else begin
      vld <= op.issue;
      if (op.clr) begin
        cos_sum <= '0;
        sin_sum <= '0;
      end else if (vld) begin
        if (dest_r == prw1_pkg::D_COS) begin
          cos_sum <= cos_sum + term[SUM_W-1:0];
        end
        if (dest_r == prw1_pkg::D_SIN) begin
          sin_sum <= sin_sum + term[SUM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod    <= a * b;
    hi_r    <= op.hi;
    sub_r   <= op.sub;
    first_r <= op.first;
    dest_r  <= op.dest;
    if (vld && dest_r == prw1_pkg::D_ACC) begin
      acc <= first_r ? term : acc + term;
    end
    unique case (op.act)
      prw1_pkg::ACT_UX:    ux    <= rnd16[SUM_W+15:16];
      prw1_pkg::ACT_UY:    uy    <= rnd16[SUM_W+15:16];
      prw1_pkg::ACT_THETA: theta <= sat16(q);
      prw1_pkg::ACT_NONE:  ;
    endcase
  end

endmodule

>>> rtl/prw1_seq.sv
// Sequencer: steps the shared multiply-accumulate unit through sample
// accumulation, coefficient scaling and per-point rebuild. Depends on prw1_pkg.
`timescale 1ns / 1ps

module prw1_seq #(
  parameter int MAX_RING = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_accept,
  input  logic                          out_free,
  input  logic                          south,
  input  logic [prw1_pkg::RSZ_W-1:0]    ring_size,
  input  logic [prw1_pkg::STEP_W-1:0]   phase_step,
  output logic                          ready,
  output logic                          out_load,
  output logic                          out_last,
  output logic [prw1_pkg::STEP_W-1:0]   trig_phase,
  output prw1_pkg::mac_op_t             op
);

  localparam int IDX_W = $clog2(MAX_RING + 1);
  localparam int STP_W = 4;
  localparam logic [STP_W-1:0] ACC_LAST   = 4'd2;
  localparam logic [STP_W-1:0] SCALE_LAST = 4'd6;
  localparam logic [STP_W-1:0] POINT_EMIT = 4'd10;

  prw1_pkg::state_t             state;
  prw1_pkg::state_t             state_next;
  logic [STP_W-1:0]             step;
  logic [STP_W-1:0]             step_next;
  logic [IDX_W-1:0]             sample_index;
  logic [IDX_W-1:0]             sample_index_next;
  logic [prw1_pkg::STEP_W-1:0]  phase_acc;
  logic [prw1_pkg::STEP_W-1:0]  phase_acc_next;
  logic [prw1_pkg::STEP_W-1:0]  pt_phase;
  logic [prw1_pkg::STEP_W-1:0]  pt_phase_next;
  logic [IDX_W-1:0]             point;
  logic [IDX_W-1:0]             point_next;

  logic [IDX_W-1:0]             len;
  logic [IDX_W-1:0]             idx_inc;
  logic [IDX_W-1:0]             pt_inc;
  logic [prw1_pkg::STEP_W-1:0]  tpc;
  logic [prw1_pkg::STEP_W-1:0]  tps;

  always_comb begin
    if (ring_size == '0) begin
      len = IDX_W'(1);
    end else if (ring_size > prw1_pkg::RSZ_W'(MAX_RING)) begin
      len = IDX_W'(MAX_RING);
    end else begin
      len = ring_size[IDX_W-1:0];
    end
    idx_inc = sample_index + IDX_W'(1);
    pt_inc  = point + IDX_W'(1);
    tpc     = pt_phase;
    tps     = pt_phase - prw1_pkg::QUARTER_TURN;
  end

  always_comb begin
    state_next        = state;
    step_next         = step;
    sample_index_next = sample_index;
    phase_acc_next    = phase_acc;
    pt_phase_next     = pt_phase;
    point_next        = point;
    unique case (state)
      prw1_pkg::S_IDLE: begin
        if (in_accept) begin
          state_next = prw1_pkg::S_ACC;
          step_next  = '0;
        end
      end
      prw1_pkg::S_ACC: begin
        step_next = step + STP_W'(1);
        if (step == ACC_LAST) begin
          step_next = '0;
          if (idx_inc >= len) begin
            state_next        = prw1_pkg::S_SCALE;
            sample_index_next = '0;
            phase_acc_next    = '0;
          end else begin
            state_next        = prw1_pkg::S_IDLE;
            sample_index_next = idx_inc;
            phase_acc_next    = phase_acc + phase_step;
          end
        end
      end
      prw1_pkg::S_SCALE: begin
        step_next = step + STP_W'(1);
        if (step == SCALE_LAST) begin
          state_next    = prw1_pkg::S_POINT;
          step_next     = '0;
          pt_phase_next = '0;
          point_next    = '0;
        end
      end
      prw1_pkg::S_POINT: begin
        if (step == POINT_EMIT) begin
          if (out_free) begin
            step_next     = '0;
            point_next    = pt_inc;
            pt_phase_next = pt_phase + phase_step;
            if (pt_inc == len) begin
              state_next = prw1_pkg::S_IDLE;
            end
          end
        end else begin
          step_next = step + STP_W'(1);
        end
      end
    endcase
  end

  always_comb begin
    op         = '0;
    trig_phase = phase_acc;
    ready      = 1'b0;
    out_load   = 1'b0;
    out_last   = (pt_inc == len);
    unique case (state)
      prw1_pkg::S_IDLE: begin
        ready = 1'b1;
      end
      prw1_pkg::S_ACC: begin
        op.asel = prw1_pkg::A_SAMPLE;
        if (step == 4'd1) begin
          op.issue   = 1'b1;
          op.dest    = prw1_pkg::D_COS;
          trig_phase = phase_acc - prw1_pkg::QUARTER_TURN;
        end else if (step == ACC_LAST) begin
          op.issue = 1'b1;
          op.dest  = prw1_pkg::D_SIN;
        end
      end
      prw1_pkg::S_SCALE: begin
        op.b_coef = 1'b1;
        op.dest   = prw1_pkg::D_ACC;
        unique case (step)
          4'd0: begin
            op.issue = 1'b1;
            op.asel  = prw1_pkg::A_COS;
            op.first = 1'b1;
          end
          4'd1: begin
            op.issue = 1'b1;
            op.asel  = prw1_pkg::A_COS;
            op.hi    = 1'b1;
          end
          4'd3: begin
            op.issue = 1'b1;
            op.asel  = prw1_pkg::A_SIN;
            op.first = 1'b1;
            op.act   = prw1_pkg::ACT_UX;
          end
          4'd4: begin
            op.issue = 1'b1;
            op.asel  = prw1_pkg::A_SIN;
            op.hi    = 1'b1;
          end
          SCALE_LAST: begin
            op.act = prw1_pkg::ACT_UY;
            op.clr = 1'b1;
          end
          default: ;
        endcase
      end
      prw1_pkg::S_POINT: begin
        op.dest    = prw1_pkg::D_ACC;
        trig_phase = tpc;
        unique case (step)
          4'd1: begin
            op.issue = 1'b1;
            op.asel  = prw1_pkg::A_UX;
            op.first = 1'b1;
            op.sub   = south;
          end
          4'd2: begin
            op.issue   = 1'b1;
            op.asel    = prw1_pkg::A_UX;
            op.hi      = 1'b1;
            op.sub     = south;
            trig_phase = tps;
          end
          4'd3: begin
            op.issue   = 1'b1;
            op.asel    = prw1_pkg::A_UY;
            op.sub     = south;
            trig_phase = tps;
          end
          4'd4: begin
            op.issue = 1'b1;
            op.asel  = prw1_pkg::A_UY;
            op.hi    = 1'b1;
            op.sub   = south;
          end
          4'd5: begin
            op.issue = 1'b1;
            op.asel  = prw1_pkg::A_UY;
            op.first = 1'b1;
          end
          4'd6: begin
            op.issue   = 1'b1;
            op.asel    = prw1_pkg::A_UY;
            op.hi      = 1'b1;
            op.act     = prw1_pkg::ACT_THETA;
            trig_phase = tps;
          end
          4'd7: begin
            op.issue   = 1'b1;
            op.asel    = prw1_pkg::A_UX;
            op.sub     = 1'b1;
            trig_phase = tps;
          end
          4'd8: begin
            op.issue = 1'b1;
            op.asel  = prw1_pkg::A_UX;
            op.hi    = 1'b1;
            op.sub   = 1'b1;
          end
          POINT_EMIT: begin
            out_load = out_free;
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= prw1_pkg::S_IDLE;
      step         <= '0;
      sample_index <= '0;
      phase_acc    <= '0;
      pt_phase     <= '0;
      point        <= '0;
    end else begin
      state        <= state_next;
      step         <= step_next;
      sample_index <= sample_index_next;
      phase_acc    <= phase_acc_next;
      pt_phase     <= pt_phase_next;
      point        <= point_next;
    end
  end

endmodule

>>> rtl/pole_ring_wavenumber_one_filter.sv
// Top level of the pole ring wavenumber-one filter: stream ports, register
// file, output register. Uses prw1_pkg, prw1_seq, prw1_mac, prw1_trig_rom.
// Each sample is accepted while idle, then runs three sequencer steps; the ring's
// last sample adds 7 scaling steps, then the rebuild of each of the L results runs
// 11 steps, the last of which waits until the output is free. Reset clears sums,
// counters, handshake, register defaults.
`timescale 1ns / 1ps

module pole_ring_wavenumber_one_filter #(
  parameter int MAX_RING        = 64,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic [0:0]  s_axis_tuser,   // [0] south_pole
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] theta_vel, [31:16] phi_vel
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [prw1_pkg::CFG_W-1:0] cfg_data
);

  logic [prw1_pkg::RSZ_W-1:0]           ring_size;
  logic [prw1_pkg::STEP_W-1:0]          phase_step;
  logic [prw1_pkg::COEF_W-1:0]          coef_scale;
  logic signed [prw1_pkg::SAMPLE_W-1:0] sample;
  logic                                 south;
  logic                                 in_accept;
  logic                                 out_free;
  logic                                 out_load;
  logic                                 out_last;
  logic [prw1_pkg::STEP_W-1:0]          trig_phase;
  logic signed [prw1_pkg::TRIG_W-1:0]   trig_val;
  logic signed [prw1_pkg::OUT_W-1:0]    theta;
  logic signed [prw1_pkg::OUT_W-1:0]    phi;
  prw1_pkg::mac_op_t                    op;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size  <= 7'd64;
      phase_step <= 16'd1024;
      coef_scale <= 17'd2048;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prw1_pkg::REG_RING_SIZE:  ring_size  <= cfg_data[prw1_pkg::RSZ_W-1:0];
        prw1_pkg::REG_PHASE_STEP: phase_step <= cfg_data[prw1_pkg::STEP_W-1:0];
        prw1_pkg::REG_COEF_SCALE: coef_scale <= cfg_data[prw1_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample <= s_axis_tdata;
      south  <= s_axis_tuser[0];
    end
  end

  prw1_seq #(
    .MAX_RING (MAX_RING)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .out_free   (out_free),
    .south      (south),
    .ring_size  (ring_size),
    .phase_step (phase_step),
    .ready      (s_axis_tready),
    .out_load   (out_load),
    .out_last   (out_last),
    .trig_phase (trig_phase),
    .op         (op)
  );

  prw1_trig_rom #(
    .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
  ) u_rom (
    .clk      (clk),
    .phase    (trig_phase),
    .trig_val (trig_val)
  );

  prw1_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .sample (sample),
    .coef   (coef_scale),
    .trig   (trig_val),
    .theta  (theta),
    .phi    (phi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {phi, theta};
      m_axis_tlast <= out_last;
    end
  end

endmodule

>>> verif/tb_top.sv
// Self-checking bench for the pole ring wavenumber-one filter: streams rings of
// samples with random gaps and stalls and predicts every rebuilt point in a
// fixed-point model of its own. Needs prw1_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;
  import prw1_pkg::*;

  localparam int RING_MAX  = 64;
  localparam int TRIG_BITS = 10;
  localparam int QTR_LEN   = 1 << (TRIG_BITS - 2);
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int ITEM_TARGET   = 290;
  localparam int CALM_FROM     = 230;

  typedef struct packed {
    logic [15:0] theta;
    logic [15:0] phi;
    logic        last;
  } ring_point_t;

  class ring_scoreboard;
    int errors;
    ring_point_t points_due[$];
    int quarter_cos[QTR_LEN + 1];
    logic [RSZ_W-1:0]  ring_size;
    logic [STEP_W-1:0] phase_step;
    logic [COEF_W-1:0] coef_scale;
    longint cos_acc;
    longint sin_acc;
    int count;
    logic [STEP_W-1:0] phase;

    function new();
      longint unsigned x, x2, term;
      longint acc;
      errors = 0;
      for (int j = 0; j <= QTR_LEN; j++) begin
        x = (PI_Q30 * 2 * longint'(j)) >> TRIG_BITS;
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        acc = longint'(term);
        for (int k = 1; k <= 10; k++) begin
          term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
          if (k % 2 == 1) acc -= longint'(term);
          else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        acc = (acc + 16384) >>> 15;
        quarter_cos[j] = (acc > 32767) ? 32767 : int'(acc);
      end
      ring_size  = 64;
      phase_step = 1024;
      coef_scale = 2048;
      cos_acc = 0;
      sin_acc = 0;
      count = 0;
      phase = '0;
    endfunction

    function int cos_of(logic [STEP_W-1:0] ph);
      logic [TRIG_BITS-1:0] i;
      int r;
      i = ph[STEP_W-1 -: TRIG_BITS];
      r = int'(i[TRIG_BITS-3:0]);
      case (i[TRIG_BITS-1 -: 2])
        2'd0: return quarter_cos[r];
        2'd1: return -quarter_cos[QTR_LEN - r];
        2'd2: return -quarter_cos[r];
        default: return quarter_cos[QTR_LEN - r];
      endcase
    endfunction

    function longint round_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function logic [15:0] clip16(longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
    endfunction

    function void set_reg(reg_idx_t r, logic [CFG_W-1:0] v);
      case (r)
        REG_RING_SIZE:  ring_size  = v[RSZ_W-1:0];
        REG_PHASE_STEP: phase_step = v[STEP_W-1:0];
        REG_COEF_SCALE: coef_scale = v[COEF_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [15:0] smp, logic south);
      longint s, ux, uy, c, sn, th, pv;
      int len;
      logic [STEP_W-1:0] ph;
      ring_point_t p;
      len = (ring_size == 0) ? 1 : ((ring_size > RING_MAX) ? RING_MAX : int'(ring_size));
      s = longint'($signed(smp));
      cos_acc += s * cos_of(phase);
      sin_acc += s * cos_of(phase - QUARTER_TURN);
      phase = phase + phase_step;
      count = (count + 1) % 128;
      if (count < len) return;
      ux = round_shift(cos_acc * longint'(coef_scale), 16);
      uy = round_shift(sin_acc * longint'(coef_scale), 16);
      for (int k = 0; k < len; k++) begin
        ph = 16'(k * int'(phase_step));
        c = cos_of(ph);
        sn = cos_of(ph - QUARTER_TURN);
        th = ux * c + uy * sn;
        pv = uy * c - ux * sn;
        if (south) th = -th;
        p.theta = clip16(round_shift(th, 30));
        p.phi = clip16(round_shift(pv, 30));
        p.last = (k == len - 1);
        points_due.push_back(p);
      end
      cos_acc = 0;
      sin_acc = 0;
      count = 0;
      phase = '0;
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_point(logic [31:0] data, logic last);
      ring_point_t want;
      if (points_due.size() == 0) begin
        report($sformatf("unexpected point theta %0d phi %0d last %b",
                         $signed(data[15:0]), $signed(data[31:16]), last));
        return;
      end
      want = points_due.pop_front();
      if (data[15:0] !== want.theta)
        report($sformatf("theta %0d, want %0d", $signed(data[15:0]), $signed(want.theta)));
      if (data[31:16] !== want.phi)
        report($sformatf("phi %0d, want %0d", $signed(data[31:16]), $signed(want.phi)));
      if (last !== want.last)
        report($sformatf("last %b, want %b", last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ring_scoreboard sb;
  bit calm = 1'b0;
  int hold_tick = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  pole_ring_wavenumber_one_filter uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: check accepted points, then pick next ready
  initial begin
    int idle_left;
    int hold_left;
    int hold_seen;
    idle_left = 0;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready)
        sb.check_point(m_axis_tdata, m_axis_tlast);
      if (hold_tick != hold_seen) begin
        hold_seen = hold_tick;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(1, 7) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [15:0] smp, input logic south);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    s_axis_tuser <= south;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_sample(smp, south);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.points_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // negative value: leave that register alone
  task automatic program_regs(input int rs, input int ps, input int cs);
    int vals[3];
    reg_idx_t r;
    vals = '{rs, ps, cs};
    r = REG_RING_SIZE;
    for (int i = 0; i < 3; i++) begin
      if (vals[i] >= 0) begin
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= vals[i][CFG_W-1:0];
        sb.set_reg(r, vals[i][CFG_W-1:0]);
        @(posedge clk);
      end
      r = r.next();
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3, 4: return 16'($urandom_range(0, 8192) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int ring_len(int rs);
    return (rs == 0) ? 1 : ((rs > RING_MAX) ? RING_MAX : rs);
  endfunction

  task automatic send_rings(input int len, input int rings);
    for (int r = 0; r < rings; r++)
      for (int i = 0; i < len; i++)
        send_item(pick_sample(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int rs, ps, cs, len;
    sb = new();
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_RING_SIZE;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short ring on the reset step and scale
    program_regs(2, -1, -1);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h8000, 1'b0);
    wait_idle();

    // quarter-turn step, largest scale: saturate both poles
    program_regs(4, 16384, 131071);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h1234, 1'b1);
    send_item(16'h8000, 1'b1);
    send_item(16'h0001, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h8000, 1'b1);
    wait_idle();

    // zero ring size acts as one, zero step and scale
    program_regs(0, 0, 0);
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b1);
    wait_idle();

    // oversized ring clamps; shrink it mid-ring so the next sample ends it
    program_regs(127, 65535, 65536);
    send_item(16'h4000, 1'b0);
    send_item(16'hC000, 1'b1);
    send_item(16'h2AAA, 1'b0);
    wait_idle();
    program_regs(1, 40000, 65536);
    send_item(16'h5555, 1'b1);
    wait_idle();

    program_regs(5, 13107, 98304);
    send_item(16'h0001, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h7FFF, 1'b1);
    send_item(16'h8001, 1'b0);
    send_item(16'h0800, 1'b0);
    wait_idle();

    // long result-side hold while rings keep coming
    program_regs(20, $urandom_range(0, 65535), $urandom_range(0, 131071));
    hold_tick++;
    send_rings(20, 3);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_FROM) calm = 1'b1;
      wait_idle();
      case ($urandom_range(0, 11))
        0: rs = 0;
        1: rs = RING_MAX;
        2: rs = $urandom_range(RING_MAX + 1, 127);
        3: rs = $urandom_range(17, 40);
        default: rs = $urandom_range(1, 12);
      endcase
      len = ring_len(rs);
      case ($urandom_range(0, 5))
        0: ps = 0;
        1: ps = 65535;
        2: ps = 16384;
        3: ps = 65536 / len % 65536;
        default: ps = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 5))
        0: cs = 0;
        1: cs = 131071;
        2: cs = 65536;
        default: cs = $urandom_range(0, 131071);
      endcase
      program_regs(rs, ps, cs);
      send_rings(len, (len > 16) ? 1 : $urandom_range(1, 3));
      // leave a ring open so the next register write lands inside it
      if (len > 1 && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, len - 1))
          send_item(pick_sample(), 1'($urandom_range(0, 1)));
    end
    wait_idle();

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
